@@ hdl/asis_pkg.sv @@
// shared constants and result type for the adc scan smoother
`default_nettype none
package asis_pkg;

    localparam int CHANNELS      = 6;
    localparam int SLOTS         = 8;
    localparam int CH_W          = 3;
    localparam int RAW_W         = 10;
    localparam int VAL_W         = 16;
    localparam int RAW_LOW_SHIFT = 4;
    localparam int EMA_SHIFT     = 3;

    typedef struct packed {
        logic             accepted;
        logic [CH_W-1:0]  sample_channel;
        logic [VAL_W-1:0] filtered_value;
        logic [CH_W-1:0]  mux_channel;
    } t_result;

endpackage
`default_nettype wire

@@ hdl/asis_in_stage.sv @@
// input register holding one conversion result
`default_nettype none
module asis_in_stage (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_in_valid,
    output logic                      o_in_ready,
    input  wire  [asis_pkg::RAW_W-1:0] i_raw_sample,
    input  wire                       i_advance,
    output logic                      o_valid,
    output logic [asis_pkg::RAW_W-1:0] o_raw
);
    import asis_pkg::*;

    logic             r_valid;
    logic [RAW_W-1:0] r_raw;

    assign o_in_ready = !r_valid || i_advance;
    assign o_valid    = r_valid;
    assign o_raw      = r_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_raw <= i_raw_sample;
        end
    end

endmodule
`default_nettype wire

@@ hdl/asis_channel_filter.sv @@
// scan state, per-channel filter store and the update logic
`default_nettype none
module asis_channel_filter (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_fire,
    input  wire  [asis_pkg::RAW_W-1:0] i_raw,
    output asis_pkg::t_result          o_result
);
    import asis_pkg::*;

    logic [CH_W-1:0]  r_channel;
    logic             r_discard;
    logic             r_seeded [SLOTS];
    logic [VAL_W-1:0] r_filter [SLOTS];

    logic [VAL_W-1:0]        old_val;
    logic [VAL_W-1:0]        wide;
    logic signed [VAL_W:0]   err;
    logic signed [VAL_W:0]   step;
    logic signed [VAL_W:0]   sum;
    logic [VAL_W-1:0]        n_value;
    logic [CH_W:0]           inc;
    logic [CH_W-1:0]         n_channel;

    always_comb begin
        old_val = r_filter[r_channel];
        wide    = {i_raw, i_raw[RAW_W-1:RAW_LOW_SHIFT]};
        err     = $signed({1'b0, wide}) - $signed({1'b0, old_val});
        step    = err >>> EMA_SHIFT;
        sum     = $signed({1'b0, old_val}) + step;
        n_value = r_seeded[r_channel] ? sum[VAL_W-1:0] : wide;
        inc     = {1'b0, r_channel} + (CH_W+1)'(1);
        n_channel = (inc >= (CH_W+1)'(CHANNELS)) ? '0 : inc[CH_W-1:0];

        o_result.sample_channel = r_channel;
        if (r_discard) begin
            o_result.accepted       = 1'b0;
            o_result.filtered_value = old_val;
            o_result.mux_channel    = r_channel;
        end else begin
            o_result.accepted       = 1'b1;
            o_result.filtered_value = n_value;
            o_result.mux_channel    = n_channel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel <= '0;
            r_discard <= 1'b1;
            for (int i = 0; i < SLOTS; i++) begin
                r_seeded[i] <= 1'b0;
                r_filter[i] <= '0;
            end
        end else if (i_fire) begin
            if (r_discard) begin
                r_discard <= 1'b0;
            end else begin
                r_discard            <= 1'b1;
                r_channel            <= n_channel;
                r_seeded[r_channel]  <= 1'b1;
                r_filter[r_channel]  <= n_value;
            end
        end
    end

endmodule
`default_nettype wire

@@ hdl/adc_scan_iir_smoother.sv @@
// top level: multichannel adc scan with per-channel exponential moving average
//
//  channel | handshake                 | payload
//  input   | i_in_valid / o_in_ready   | i_raw_sample
//  output  | o_out_valid / i_out_ready | o_accepted, o_sample_channel,
//          |                           | o_filtered_value, o_mux_channel
//
// one transaction per cycle sustained unless the output stalls; from input to result:
// input register, then the filter update, then the result register
// channel state is updated in the same cycle the result register loads
// synchronous active-low reset clears scan state and all filter slots
// a stalled result holds the pipeline; the input register still fills only while empty
`default_nettype none
module adc_scan_iir_smoother (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_ready,
    input  wire  [asis_pkg::RAW_W-1:0]  i_raw_sample,
    output logic                        o_out_valid,
    input  wire                         i_out_ready,
    output logic                        o_accepted,
    output logic [asis_pkg::CH_W-1:0]   o_sample_channel,
    output logic [asis_pkg::VAL_W-1:0]  o_filtered_value,
    output logic [asis_pkg::CH_W-1:0]   o_mux_channel
);
    import asis_pkg::*;

    logic             stage_valid;
    logic [RAW_W-1:0] stage_raw;
    logic             advance;
    t_result          result;
    logic             r_out_valid;
    t_result          r_out;

    assign advance = stage_valid && (!r_out_valid || i_out_ready);

    asis_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_raw_sample (i_raw_sample),
        .i_advance    (advance),
        .o_valid      (stage_valid),
        .o_raw        (stage_raw)
    );

    asis_channel_filter u_filter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_raw    (stage_raw),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            r_out_valid <= stage_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_accepted       = r_out.accepted;
    assign o_sample_channel = r_out.sample_channel;
    assign o_filtered_value = r_out.filtered_value;
    assign o_mux_channel    = r_out.mux_channel;

endmodule
`default_nettype wire
